// ----- rtl/ceob_pkg.sv -----
// ----------------------------------------------------------------------------
// ceob_pkg: shared types and constants of the cell edge orientation binner
// Holds the arctangent table, the angle scale and the inter-module struct.
// ----------------------------------------------------------------------------
`default_nettype none
package ceob_pkg;

    localparam int MAX_BINS     = 16;
    localparam int GRAD_BITS    = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 20;   // z within +-2^16 with margin
    localparam int CXY_BITS     = 24;   // 12-bit gradient scaled by 256, plus growth
    localparam int CFG_BIN_COUNT = 0;
    localparam int CFG_THRESHOLD = 1;

    function automatic logic signed [ANGLE_BITS-1:0] atan_units(input logic [3:0] i);
        logic signed [ANGLE_BITS-1:0] t;
        begin
            case (i)
                4'd0:    t = 20'sd8192;
                4'd1:    t = 20'sd4836;
                4'd2:    t = 20'sd2555;
                4'd3:    t = 20'sd1297;
                4'd4:    t = 20'sd651;
                4'd5:    t = 20'sd326;
                4'd6:    t = 20'sd163;
                4'd7:    t = 20'sd81;
                4'd8:    t = 20'sd41;
                4'd9:    t = 20'sd20;
                4'd10:   t = 20'sd10;
                4'd11:   t = 20'sd5;
                4'd12:   t = 20'sd3;
                4'd13:   t = 20'sd1;
                4'd14:   t = 20'sd1;
                default: t = 20'sd0;
            endcase
            return t;
        end
    endfunction

    typedef struct packed {
        logic                         vld;
        logic signed [CXY_BITS-1:0]   x;
        logic signed [CXY_BITS-1:0]   y;
        logic signed [ANGLE_BITS-1:0] z;
        logic                         zero;
    } t_cordic;

endpackage
`default_nettype wire

// ----- rtl/ceob_cell.sv -----
// ----------------------------------------------------------------------------
// ceob_cell: one CORDIC rotation cell
// Performs one vectoring iteration with a fixed shift and hands on the result.
// ----------------------------------------------------------------------------
`default_nettype none
module ceob_cell
    import ceob_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_en,
    input  t_cordic i_d,
    output t_cordic o_d
);
    t_cordic r_d;
    t_cordic n_d;
    logic signed [CXY_BITS-1:0] xs, ys;
    logic signed [ANGLE_BITS-1:0] t;

    always_comb begin
        xs = i_d.x >>> STEP;
        ys = i_d.y >>> STEP;
        t  = atan_units(4'(STEP));
        n_d = i_d;
        if (!i_d.y[CXY_BITS-1]) begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + t;
        end else begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - t;
        end
    end

    // The cell holds its contents while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
        if (!i_rst_n) r_d.vld <= 1'b0;
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

// ----- rtl/cell_edge_orientation_binner_core.sv -----
// ----------------------------------------------------------------------------
// cell_edge_orientation_binner_core: orientation histogram with argmax per cell
// Bins gradient pixels by CORDIC angle and reports the strongest bin per cell.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tdata {grad_y, grad_x}, tlast = cell_end
// m_axis    out        tdata {draw, bin_index}
// cfg       in         write enable, index, data (bin_count, threshold)
//
// A pixel passes an input register, a row of 16 CORDIC cells, a quantizer
// stage (multiply by the bin count), a round/modulo stage and an accumulation
// stage before it lands in its bin; one pixel transaction is accepted per
// cycle while the pipeline flows. At a cell end the closing sweep walks the
// bins, one per cycle, and clears each one; the result becomes valid once
// the sweep has passed every bin. Input is held off during the sweep and
// while the result waits. Reset is synchronous and active low. An output
// stall freezes the whole pipeline.
`default_nettype none
module cell_edge_orientation_binner_core
    import ceob_pkg::*;
#(
    parameter int MAX_CELL_PIXELS = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // [11:0] grad_x, [23:12] grad_y
    input  wire         s_axis_tlast,   // cell_end
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] bin_index, [4] draw, rest zero
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_wdata
);
    localparam int BW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NW  = $clog2(MAX_BINS + 1);
    localparam int PW  = $clog2(MAX_CELL_PIXELS + 1);
    localparam int DEP = CORDIC_STEPS + 1;

    // configuration
    logic [4:0]  r_bin_count;
    logic [23:0] r_threshold;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= 5'd4;
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'(CFG_BIN_COUNT)) r_bin_count <= i_cfg_wdata[4:0];
            else                                 r_threshold <= i_cfg_wdata;
        end
    end
    logic [NW-1:0] eff_n;
    always_comb begin
        if (r_bin_count == 5'd0) eff_n = NW'(1);
        else if (32'(r_bin_count) > MAX_BINS) eff_n = NW'(MAX_BINS);
        else eff_n = NW'(r_bin_count);
    end

    // control: stall everything while the output is blocked or a sweep runs
    logic adv, r_sweep;
    logic r_ovld;
    assign adv = !(r_ovld && !m_axis_tready) && !r_sweep;

    // side data travelling with each pixel: weight and last flag
    logic [DEP-1:0] r_lst;
    logic [24:0]    r_w [DEP];
    logic signed [GRAD_BITS-1:0] gx, gy;
    assign gx = s_axis_tdata[GRAD_BITS-1:0];
    assign gy = s_axis_tdata[12+GRAD_BITS-1:12];

    // multiplications registered before the sum
    logic [23:0] r_sqx, r_sqy;
    always_ff @(posedge i_clk) if (adv) begin
        r_sqx <= 24'(gx) * 24'(gx);
        r_sqy <= 24'(gy) * 24'(gy);
    end

    t_cordic c_in;
    t_cordic c [CORDIC_STEPS+1];
    always_comb begin
        c_in.vld  = s_axis_tvalid && s_axis_tready;
        c_in.zero = (gx == '0) && (gy == '0);
        c_in.x    = CXY_BITS'(gx) <<< 8;
        c_in.y    = CXY_BITS'(gy) <<< 8;
        c_in.z    = '0;
        if (gx[GRAD_BITS-1]) begin
            c_in.z = gy[GRAD_BITS-1] ? -20'sd32768 : 20'sd32768;
            c_in.x = -(CXY_BITS'(gx) <<< 8);
            c_in.y = -(CXY_BITS'(gy) <<< 8);
        end
    end
    // first cell input is registered so every cell sees a register
    t_cordic r_c0;
    always_ff @(posedge i_clk) begin
        if (adv) r_c0 <= c_in;
        if (!i_rst_n) r_c0.vld <= 1'b0;
    end
    assign c[0] = r_c0;

    // the stall is global; every cell holds while adv is low
    genvar g;
    for (g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        t_cordic dout;
        ceob_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_d(c[g]), .o_d(dout));
        assign c[g+1] = dout;
    end

    // weight and last tags follow the CORDIC chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lst <= '0;
        else if (adv) begin
            r_lst <= {r_lst[DEP-2:0], s_axis_tlast && s_axis_tvalid && s_axis_tready};
        end
    end
    always_ff @(posedge i_clk) if (adv) begin
        r_w[0] <= 25'(r_sqx) + 25'(r_sqy);
        for (int k = 1; k < DEP; k++) r_w[k] <= r_w[k-1];
    end
    // r_w[0] is registered from r_sqx, so it pairs with c[1], not r_c0: align by index
    localparam int TAGI = CORDIC_STEPS;   // tag slot matching c[CORDIC_STEPS]

    // quantize: v = -z * n
    t_cordic cq;
    assign cq = c[CORDIC_STEPS];
    logic signed [ANGLE_BITS+NW:0] r_v;
    logic r_vv, r_vz, r_vl;
    logic [24:0] r_vw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vv <= 1'b0;
        else if (adv) r_vv <= cq.vld;
        if (adv) begin
            r_v  <= -((ANGLE_BITS+NW+1)'(cq.z)) * $signed({1'b0, eff_n});
            r_vz <= cq.zero;
            r_vl <= r_lst[TAGI];
            r_vw <= r_w[TAGI-1];
        end
    end

    // round half away, then modulo n (|q| <= n so one fold each side)
    logic signed [ANGLE_BITS+NW:0] av;
    logic signed [NW+2:0] q, qm;
    always_comb begin
        av = r_v[ANGLE_BITS+NW] ? -r_v : r_v;
        q  = (NW+3)'((av + 16384) >>> 15);
        if (r_v[ANGLE_BITS+NW]) q = -q;
        qm = q;
        if (qm < 0) qm = qm + $signed({3'b0, eff_n});
        if (qm >= $signed({3'b0, eff_n})) qm = qm - $signed({3'b0, eff_n});
        if (r_vz) qm = '0;
    end
    logic r_bv, r_bl;
    logic [BW-1:0] r_b;
    logic [24:0] r_bw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= 1'b0;
        else if (adv) r_bv <= r_vv;
        if (adv) begin
            r_b  <= BW'(qm);
            r_bl <= r_vl;
            r_bw <= r_vw;
        end
    end

    // accumulate
    logic [31:0] r_bins [MAX_BINS];
    logic [PW-1:0] r_cnt;
    logic [32:0] sum;
    assign sum = 33'(r_bins[r_b]) + 33'(r_bw);
    logic [BW:0] r_k;
    logic [BW-1:0] r_best;
    logic [31:0] r_bmax;
    logic [36:0] r_tot;
    logic [NW-1:0] r_sn;
    logic [3:0]  r_obin;
    logic        r_odraw;
    logic [24+PW-1:0] need;
    assign need = (24+PW)'(r_threshold) * (24+PW)'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BINS; k++) r_bins[k] <= '0;
            r_cnt   <= '0;
            r_sweep <= 1'b0;
            r_ovld  <= 1'b0;
            r_k     <= '0;
        end else begin
            if (r_ovld && m_axis_tready) r_ovld <= 1'b0;
            if (adv && r_bv) begin
                r_bins[r_b] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                if (32'(r_cnt) < MAX_CELL_PIXELS) r_cnt <= r_cnt + 1'b1;
                if (r_bl) begin
                    r_sweep <= 1'b1;
                    r_k     <= '0;
                    r_tot   <= '0;
                    r_best  <= '0;
                    r_bmax  <= '0;
                    r_sn    <= eff_n;
                end
            end
            if (r_sweep) begin
                if (r_k < (BW+1)'(MAX_BINS)) begin
                    if ((NW+1)'(r_k) < (NW+1)'(r_sn)) begin
                        r_tot <= r_tot + 37'(r_bins[BW'(r_k)]);
                        if (r_k == '0 || r_bins[BW'(r_k)] > r_bmax) begin
                            r_bmax <= r_bins[BW'(r_k)];
                            r_best <= BW'(r_k);
                        end
                    end
                    r_bins[BW'(r_k)] <= '0;
                    r_k <= r_k + 1'b1;
                end else begin
                    r_sweep <= 1'b0;
                    r_ovld  <= 1'b1;
                    r_obin  <= 4'(r_best);
                    r_odraw <= (37'(r_tot) >= 37'(need));
                    r_cnt   <= '0;
                end
            end
        end
    end

    assign s_axis_tready = adv && !r_ovld;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {3'b0, r_odraw, r_obin};
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cell edge orientation binner
// Streams gradient pixels grouped into cells, predicts the winning bin and the
// draw flag with a CORDIC model of its own, and checks every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    import ceob_pkg::*;

    localparam int MAX_CELL_PIXELS = 256;
    localparam int HALF_TURN       = 32768;
    localparam int WATCHDOG_LIMIT  = 20000;

    typedef struct packed {
        logic              cell_end;
        logic signed [11:0] gy;
        logic signed [11:0] gx;
    } pixel_t;

    typedef struct packed {
        logic       draw;
        logic [3:0] bin;
    } verdict_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [7:0]  m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_wdata = '0;

    cell_edge_orientation_binner_core dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_index, .i_cfg_wdata
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Model state: histogram, pixel count and the register copies.
    logic [31:0] hist [MAX_BINS];
    int unsigned cell_pixels;
    logic [4:0]  bin_count_reg = 5'd4;
    logic [23:0] threshold_reg = '0;

    pixel_t   pending_pixels[$];
    verdict_t expected_verdicts[$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       errors = 0;
    int       quiet_cycles = 0;

    function automatic int atan_step(int i);
        int tbl[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                        41, 20, 10, 5, 3, 1, 1, 0};
        return tbl[i];
    endfunction

    // Orientation bin of one pixel for an effective bin count n.
    function automatic int orientation_of(int gx, int gy, int n);
        longint x, y, z, xs, ys, v, q;
        x = gx * 256;
        y = gy * 256;
        z = 0;
        if (gx == 0 && gy == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += atan_step(i);
            end else begin
                x = x - ys; y = y + xs; z -= atan_step(i);
            end
        end
        v = -z * n;
        if (v >= 0) q = (v + HALF_TURN / 2) / HALF_TURN;
        else        q = -((-v + HALF_TURN / 2) / HALF_TURN);
        q = q % n;
        if (q < 0) q += n;
        return int'(q);
    endfunction

    // Folds one accepted pixel into the histogram; closes the cell on its end.
    task automatic bin_pixel(input pixel_t p);
        int          n, b, best;
        longint      w, s, total, need;
        verdict_t    r;
        n = (bin_count_reg < 1) ? 1 : (bin_count_reg > MAX_BINS ? MAX_BINS : bin_count_reg);
        b = orientation_of(p.gx, p.gy, n);
        w = longint'(p.gx) * p.gx + longint'(p.gy) * p.gy;
        s = longint'(hist[b]) + w;
        hist[b] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        if (cell_pixels < MAX_CELL_PIXELS) cell_pixels++;
        if (p.cell_end) begin
            total = 0;
            best = 0;
            for (int k = 0; k < n; k++) begin
                total += hist[k];
                if (hist[k] > hist[best]) best = k;
            end
            need = longint'(threshold_reg) * cell_pixels;
            r.bin = best[3:0];
            r.draw = (total >= need);
            expected_verdicts.push_back(r);
            for (int k = 0; k < MAX_BINS; k++) hist[k] = '0;
            cell_pixels = 0;
        end
    endtask

    // Driver: one transaction per handshake, valid held high until accepted.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            bin_pixel(pending_pixels.pop_front());
        end
        if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (pending_pixels.size() > 0 && i_rst_n &&
                $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {pending_pixels[0].gy, pending_pixels[0].gx};
                s_axis_tlast  <= pending_pixels[0].cell_end;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        verdict_t got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[4:0];
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result bin=%0d draw=%0d",
                         $time, got.bin, got.draw);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                if (got.bin !== want.bin) begin
                    $display("%0t: bin_index expected %0d actual %0d",
                             $time, want.bin, got.bin);
                    errors++;
                end
                if (got.draw !== want.draw) begin
                    $display("%0t: draw expected %0d actual %0d",
                             $time, want.draw, got.draw);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles where neither side moves a transaction.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (i_rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_pixel(input int gx, input int gy, input bit last_px);
        pixel_t p;
        p.gx = gx[11:0];
        p.gy = gy[11:0];
        p.cell_end = last_px;
        pending_pixels.push_back(p);
    endtask

    // Random cell: mostly mid-size gradients, sometimes full scale or zero.
    task automatic add_cell(input int len);
        int gx, gy;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: begin gx = 0; gy = 0; end
                1, 2: begin gx = $urandom_range(4095) - 2048;
                            gy = $urandom_range(4095) - 2048; end
                default: begin gx = $urandom_range(255) - 128;
                               gy = $urandom_range(255) - 128; end
            endcase
            add_pixel(gx, gy, i == len - 1);
        end
    endtask

    // Wait until every queued pixel is in and every result is back, plus drain.
    task automatic settle();
        wait (pending_pixels.size() == 0 && !s_axis_tvalid);
        wait (expected_verdicts.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx[0:0];
        i_cfg_wdata <= value[23:0];
        if (idx == CFG_BIN_COUNT) bin_count_reg = value[4:0];
        else threshold_reg = value[23:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int bins_list[6] = '{16, 1, 0, 31, 7, 4};
        int thr_list[6]  = '{0, 16777215, 3000, 0, 100000, 50};
        for (int k = 0; k < MAX_BINS; k++) hist[k] = '0;
        cell_pixels = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Directed: extremes, axes, diagonals, zero gradient, one-pixel cells.
        add_pixel(0, 0, 1);
        add_pixel(2047, 0, 1);
        add_pixel(-2048, 0, 1);
        add_pixel(0, 2047, 1);
        add_pixel(0, -2048, 1);
        add_pixel(-2048, -2048, 1);
        add_pixel(2047, 2047, 0);
        add_pixel(-2048, 2047, 0);
        add_pixel(2047, -2048, 1);
        add_pixel(-1, -1, 0);
        add_pixel(1, -1, 0);
        add_pixel(-1, 1, 0);
        add_pixel(1, 1, 1);
        add_pixel(-2048, -1, 0);
        add_pixel(-1, -2048, 1);
        settle();

        // Overlong cell: the pixel count saturates while weights keep growing.
        write_reg(CFG_THRESHOLD, 1);
        for (int i = 0; i < 300; i++) add_pixel(0, (i % 2) ? 1 : 0, i == 299);
        settle();

        // Bin count changed in the middle of a cell.
        add_cell(0);
        for (int i = 0; i < 6; i++) add_pixel(-2048, 100 * i, 0);
        settle();
        write_reg(CFG_BIN_COUNT, 3);
        add_pixel(5, 5, 1);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2)      begin send_idle_pct = 7;  recv_idle_pct = 66; end
            else if (ph < 4) begin send_idle_pct = 66; recv_idle_pct = 7;  end
            else             begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            write_reg(CFG_BIN_COUNT, bins_list[ph]);
            write_reg(CFG_THRESHOLD, thr_list[ph]);
            for (int c = 0; c < 37; c++) add_cell($urandom_range(10, 1));
            settle();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
